// ===== rtl/shift_jis_string_scanner_assert.svh =====
// Assertion macros for the Shift-JIS string scanner checker.
`ifndef SHIFT_JIS_STRING_SCANNER_ASSERT_SVH
`define SHIFT_JIS_STRING_SCANNER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SJSS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shift_jis_string_scanner: assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SJSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shift_jis_string_scanner: assertion failed");

`endif

// ===== rtl/sjss_pkg.sv =====
// Shared types, constants and byte-class functions of the Shift-JIS string scanner.
package sjss_pkg;

  localparam int unsigned PosW  = 24;
  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 24;
  localparam int unsigned ExtW  = (PosW > LenW) ? PosW : LenW;

  localparam logic [LenW-1:0] LenMax  = {LenW{1'b1}};
  localparam logic [1:0]      WideSat = 2'd2;

  localparam logic [7:0] NulByte = 8'h00;

  typedef struct packed {
    logic nul;
    logic lead;
    logic trail;
    logic breaker;
  } sjss_class_t;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic [LenW-1:0]  length;
  } sjss_result_t;

  function automatic logic is_trail(logic [7:0] b);
    return (b inside {[8'h40:8'hfc]}) && (b != 8'h7f);
  endfunction

  function automatic logic is_lead(logic [7:0] b);
    return b inside {[8'h81:8'h9f], [8'he0:8'hef]};
  endfunction

  function automatic logic is_breaker(logic [7:0] b);
    return b inside {[8'h00:8'h1f], 8'h7f, 8'h80, 8'ha0, [8'ha1:8'hdf], [8'hf0:8'hff]};
  endfunction

endpackage

// ===== rtl/sjss_byte_class.sv =====
// Byte classifier: NUL, lead, trail and run-breaking bytes.
module sjss_byte_class (
  input  logic [7:0]           byte_i,
  output sjss_pkg::sjss_class_t class_o
);

  assign class_o.nul     = (byte_i == sjss_pkg::NulByte);
  assign class_o.lead    = sjss_pkg::is_lead(byte_i);
  assign class_o.trail   = sjss_pkg::is_trail(byte_i);
  assign class_o.breaker = sjss_pkg::is_breaker(byte_i);

endmodule

// ===== rtl/sjss_run_tracker.sv =====
// Run state of the scanner: position, run start, pending lead, wide count.
module sjss_run_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  sjss_pkg::sjss_class_t             class_i,
  input  logic                              last_i,
  input  logic [sjss_pkg::AddrW-1:0]        region_base_i,
  output logic                              emit_o,
  output sjss_pkg::sjss_result_t            result_o
);

  logic [sjss_pkg::PosW-1:0] pos_q, pos_d;
  logic [sjss_pkg::PosW-1:0] start_q, start_d;
  logic                      started_q, started_d;
  logic                      lead_q, lead_d;
  logic [1:0]                count_q, count_d;

  logic                      handled;
  logic [sjss_pkg::PosW-1:0] run_start;
  logic [sjss_pkg::PosW-1:0] diff;
  logic [sjss_pkg::ExtW-1:0] diff_ext;

  always_comb begin
    pos_d     = pos_q;
    start_d   = start_q;
    started_d = started_q;
    lead_d    = lead_q;
    count_d   = count_q;
    handled   = 1'b0;
    emit_o    = 1'b0;
    run_start = start_q;
    if (step_i) begin
      // pending lead: complete the character or drop the run
      if (lead_q) begin
        if (class_i.trail) begin
          if (!started_q) begin
            start_d   = pos_q - sjss_pkg::PosW'(1);
            started_d = 1'b1;
          end
          if (count_q != sjss_pkg::WideSat) begin
            count_d = count_q + 2'd1;
          end
          lead_d  = 1'b0;
          handled = 1'b1;
        end else begin
          start_d   = '0;
          started_d = 1'b0;
          lead_d    = 1'b0;
          count_d   = '0;
        end
      end
      run_start = start_d;
      if (!handled) begin
        if (class_i.nul) begin
          emit_o    = started_d && (count_d == sjss_pkg::WideSat);
          start_d   = '0;
          started_d = 1'b0;
          lead_d    = 1'b0;
          count_d   = '0;
        end else if (class_i.lead) begin
          lead_d = 1'b1;
        end else if (class_i.breaker) begin
          start_d   = '0;
          started_d = 1'b0;
          lead_d    = 1'b0;
          count_d   = '0;
        end
      end
      if (last_i) begin
        start_d   = '0;
        started_d = 1'b0;
        lead_d    = 1'b0;
        count_d   = '0;
        pos_d     = '0;
      end else begin
        pos_d = pos_q + sjss_pkg::PosW'(1);
      end
    end
  end

  // length wraps with the position, then saturates to the port width
  assign diff     = pos_q - run_start;
  assign diff_ext = sjss_pkg::ExtW'(diff);

  always_comb begin
    result_o.address = region_base_i + sjss_pkg::AddrW'(run_start);
    if (diff_ext > sjss_pkg::ExtW'(sjss_pkg::LenMax)) begin
      result_o.length = sjss_pkg::LenMax;
    end else begin
      result_o.length = diff_ext[sjss_pkg::LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      start_q   <= '0;
      started_q <= 1'b0;
      lead_q    <= 1'b0;
      count_q   <= '0;
    end else begin
      pos_q     <= pos_d;
      start_q   <= start_d;
      started_q <= started_d;
      lead_q    <= lead_d;
      count_q   <= count_d;
    end
  end

endmodule

// ===== rtl/shift_jis_string_scanner.sv =====
// Top level of the Shift-JIS string scanner: request registers, tracker, result register.
//
// Scans a region one byte per request for NUL-terminated Shift-JIS text and
// reports each string that holds at least two double-byte characters as its
// absolute address (region_base + offset of the first double-byte character)
// and its length in bytes up to the NUL. A byte marked last_in_region closes
// the region: the run and the byte offset start over at zero afterwards.
// Throughput is one byte per clock while the output side does not stall: a byte
// is registered on accept, classified and folded into the run state once the
// result register can take an entry, and a string report lands in the result
// register at that same edge. The result register decouples the two sides;
// input stall rises only while a byte waits and the result register is full
// and stalled downstream. region_base may be written only while the block
// holds no request in flight.
module shift_jis_string_scanner (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [sjss_pkg::AddrW-1:0] cfg_wdata_i,
  // byte requests
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       last_in_region_i,
  // string reports
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sjss_pkg::AddrW-1:0] string_address_o,
  output logic [sjss_pkg::LenW-1:0]  string_length_o
);

  logic [sjss_pkg::AddrW-1:0] region_base_q;

  // input stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // result register
  logic                       out_valid_q, out_valid_d;
  logic [sjss_pkg::AddrW-1:0] out_addr_q;
  logic [sjss_pkg::LenW-1:0]  out_len_q;

  logic                   in_accept;
  logic                   out_free;
  logic                   step;
  logic                   emit;
  sjss_pkg::sjss_class_t  byte_class;
  sjss_pkg::sjss_result_t result;

  // result register can take a new entry when empty or draining this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d = in_accept || (s1_valid_q && !step);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = step && emit;
    end
  end

  sjss_byte_class u_byte_class (
    .byte_i  (s1_byte_q),
    .class_o (byte_class)
  );

  sjss_run_tracker u_run_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .class_i       (byte_class),
    .last_i        (s1_last_q),
    .region_base_i (region_base_q),
    .emit_o        (emit),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= '0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        region_base_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_in_region_i;
    end
    if (step && emit) begin
      out_addr_q <= result.address;
      out_len_q  <= result.length;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign string_address_o = out_addr_q;
  assign string_length_o  = out_len_q;

endmodule

// ===== rtl/sjss_checker.sv =====
// Port-level checker of the Shift-JIS string scanner and its bind.
`include "shift_jis_string_scanner_assert.svh"

module sjss_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [7:0]                 data_byte_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [sjss_pkg::AddrW-1:0] string_address_o,
  input logic [sjss_pkg::LenW-1:0]  string_length_o
);

  logic       in_acc;
  logic       nul_acc;
  logic       out_acc;
  logic [3:0] nul_credit_q, nul_credit_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign nul_acc = in_acc && (data_byte_i == sjss_pkg::NulByte);
  assign out_acc = out_valid_o && !out_stall_i;

  // NULs accepted minus reports taken; saturates high, never below zero
  always_comb begin
    nul_credit_d = nul_credit_q;
    if (nul_acc && !out_acc) begin
      if (nul_credit_q != 4'hf) begin
        nul_credit_d = nul_credit_q + 4'd1;
      end
    end else if (!nul_acc && out_acc) begin
      if (nul_credit_q != 4'h0) begin
        nul_credit_d = nul_credit_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nul_credit_q <= '0;
    end else begin
      nul_credit_q <= nul_credit_d;
    end
  end

  // a stalled report holds
  `SJSS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(string_address_o) && $stable(string_length_o))

  // every report follows an earlier accepted NUL
  `SJSS_ASSERT_SAME(a_report_after_nul, out_acc, nul_credit_q != 4'h0)

  // input never stalls while the result register can drain or is empty
  `SJSS_ASSERT_SAME(a_no_idle_stall, !out_valid_o || !out_stall_i, !in_stall_o)

endmodule

bind shift_jis_string_scanner sjss_checker u_sjss_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .data_byte_i      (data_byte_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .string_address_o (string_address_o),
  .string_length_o  (string_length_o)
);
